>>> hw/rtl/aarm_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the arctangent table for the rotation matrix block
// no dependencies
package aarm_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int TRIG_STAGES = 16;
  localparam int MAX_STAGES  = 24;
  localparam int STAGES      = (TRIG_STAGES > MAX_STAGES) ? MAX_STAGES : TRIG_STAGES;

  localparam int TURN_UNITS       = 23040;
  localparam int QUARTER_UNITS    = 5760;
  localparam int RAD_PER_UNIT_Q30 = 292818;
  localparam int CORDIC_GAIN_Q30  = 652032874;

  localparam int IN_W  = 16;
  localparam int CW    = 34;            // cordic datapath, Q1.30 with headroom
  localparam int C_W   = FRAC_BITS + 4; // sine, cosine and 1 - cos
  localparam int OUT_W = 17;
  localparam int OUT_MAX = 65535;
  localparam int OUT_MIN = -65536;

  typedef logic signed [IN_W-1:0] in_word_t;
  typedef logic signed [CW-1:0]   cword_t;
  typedef logic signed [C_W-1:0]  trig_t;
  typedef logic signed [OUT_W-1:0] elem_t;

  typedef struct packed {
    in_word_t x;
    in_word_t y;
    in_word_t z;
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // round(atan(2^-i) * 2^30)
  function automatic cword_t atan_q30(input int idx);
    cword_t v;
    case (idx)
      0:       v = CW'(843314857);
      1:       v = CW'(497837829);
      2:       v = CW'(263043837);
      3:       v = CW'(133525159);
      4:       v = CW'(67021687);
      5:       v = CW'(33543516);
      6:       v = CW'(16775851);
      7:       v = CW'(8388437);
      8:       v = CW'(4194283);
      9:       v = CW'(2097149);
      10:      v = CW'(1048576);
      11:      v = CW'(524288);
      12:      v = CW'(262144);
      13:      v = CW'(131072);
      14:      v = CW'(65536);
      15:      v = CW'(32768);
      16:      v = CW'(16384);
      17:      v = CW'(8192);
      18:      v = CW'(4096);
      19:      v = CW'(2048);
      20:      v = CW'(1024);
      21:      v = CW'(512);
      22:      v = CW'(256);
      23:      v = CW'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/aarm_if.sv
`timescale 1ns / 1ps
// valid/ready stream interfaces for the request and result channels
// depends on aarm_pkg
interface aarm_req_if;
  logic                valid;
  logic                ready;
  aarm_pkg::in_word_t  angle_deg;
  aarm_pkg::in_word_t  axis_x;
  aarm_pkg::in_word_t  axis_y;
  aarm_pkg::in_word_t  axis_z;

  modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

interface aarm_rsp_if;
  logic             valid;
  logic             ready;
  aarm_pkg::elem_t  m_r0c0;
  aarm_pkg::elem_t  m_r0c1;
  aarm_pkg::elem_t  m_r0c2;
  aarm_pkg::elem_t  m_r1c0;
  aarm_pkg::elem_t  m_r1c1;
  aarm_pkg::elem_t  m_r1c2;
  aarm_pkg::elem_t  m_r2c0;
  aarm_pkg::elem_t  m_r2c1;
  aarm_pkg::elem_t  m_r2c2;
  logic             clipped;

  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, clipped, input ready);
  modport sink   (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, clipped, output ready);
endinterface

>>> hw/rtl/axis_angle_rotation_matrix_top.sv
`timescale 1ns / 1ps
// axis-angle (rodrigues) 3x3 rotation matrix, pipelined
// depends on aarm_pkg, aarm_if and aarm_cordic
//
// usage:
//   req carries one request: angle_deg in 1/64 degree (any 16-bit value, wraps
//   modulo one turn) and the axis x, y, z in q1.14, used as given.
//   rsp returns the nine q2.14 elements row-major, each saturated to 17 bits,
//   and clipped, set when any element saturated.
//   both channels move a request when valid and ready are high at a clock edge.
// throughput: one request per cycle while rsp is not stalled. the pipeline has no bubbles of its own.
// path: from acceptance to rsp.valid a request goes through angle reduction,
//   quadrant split and radian scaling, the cordic iterations, quadrant folding
//   and rounding, then the products, the scaling by 1 - cos and the final sums
//   with saturation.
// stall: when rsp.valid is high and rsp.ready low the whole pipeline holds
//   and req.ready drops; nothing is lost or repeated.
// reset: rst (synchronous) clears all valid bits; rsp.valid is low after it.
module axis_angle_rotation_matrix_top (
  input logic        clk,
  input logic        rst,
  aarm_req_if.sink   req,
  aarm_rsp_if.source rsp
);

  localparam int F      = aarm_pkg::FRAC_BITS;
  localparam int C_W    = aarm_pkg::C_W;
  localparam int HALF   = 1 << (F - 1);
  localparam int UV_W   = 34 - F;
  localparam int UVP_W  = UV_W + C_W;
  localparam int UVO_W  = UVP_W - F + 1;
  localparam int WSP_W  = aarm_pkg::IN_W + C_W;
  localparam int WS_W   = WSP_W - F + 1;
  localparam int MAX_W  = (UVO_W > WS_W) ? UVO_W : WS_W;
  localparam int SUM_W  = ((MAX_W > C_W) ? MAX_W : C_W) + 2;

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  aarm_pkg::axis_t in_axis;
  assign in_axis = '{x: req.axis_x, y: req.axis_y, z: req.axis_z};

  logic            t_valid;
  aarm_pkg::trig_t t_cos, t_sin;
  aarm_pkg::axis_t t_axis;

  aarm_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (req.valid),
    .angle    (req.angle_deg),
    .in_axis  (in_axis),
    .out_valid(t_valid),
    .out_cos  (t_cos),
    .out_sin  (t_sin),
    .out_axis (t_axis)
  );

  // stage p1: axis products and sine terms
  logic signed [31:0]       pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [WSP_W-1:0]  pxs, pys, pzs;
  logic signed [UV_W-1:0]   xx, yy, zz, xy, xz, yz;
  logic signed [WS_W-1:0]   xs, ys, zs;
  logic signed [C_W-1:0]    c1, o1;
  logic                     p1_valid;

  always_comb begin
    pxx = 32'(t_axis.x) * 32'(t_axis.x);
    pyy = 32'(t_axis.y) * 32'(t_axis.y);
    pzz = 32'(t_axis.z) * 32'(t_axis.z);
    pxy = 32'(t_axis.x) * 32'(t_axis.y);
    pxz = 32'(t_axis.x) * 32'(t_axis.z);
    pyz = 32'(t_axis.y) * 32'(t_axis.z);
    pxs = WSP_W'(t_axis.x) * WSP_W'(t_sin);
    pys = WSP_W'(t_axis.y) * WSP_W'(t_sin);
    pzs = WSP_W'(t_axis.z) * WSP_W'(t_sin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx <= UV_W'((pxx + 32'(HALF)) >>> F);
      yy <= UV_W'((pyy + 32'(HALF)) >>> F);
      zz <= UV_W'((pzz + 32'(HALF)) >>> F);
      xy <= UV_W'((pxy + 32'(HALF)) >>> F);
      xz <= UV_W'((pxz + 32'(HALF)) >>> F);
      yz <= UV_W'((pyz + 32'(HALF)) >>> F);
      xs <= WS_W'((pxs + WSP_W'(HALF)) >>> F);
      ys <= WS_W'((pys + WSP_W'(HALF)) >>> F);
      zs <= WS_W'((pzs + WSP_W'(HALF)) >>> F);
      c1 <= t_cos;
      o1 <= C_W'(1 << F) - t_cos;
    end
  end

  // stage p2: scale the symmetric terms by 1 - cos
  logic signed [UVP_W-1:0] qxx, qyy, qzz, qxy, qxz, qyz;
  logic signed [UVO_W-1:0] xxo, yyo, zzo, xyo, xzo, yzo;
  logic signed [WS_W-1:0]  xs2, ys2, zs2;
  logic signed [C_W-1:0]   c2;
  logic                    p2_valid;

  always_comb begin
    qxx = UVP_W'(xx) * UVP_W'(o1);
    qyy = UVP_W'(yy) * UVP_W'(o1);
    qzz = UVP_W'(zz) * UVP_W'(o1);
    qxy = UVP_W'(xy) * UVP_W'(o1);
    qxz = UVP_W'(xz) * UVP_W'(o1);
    qyz = UVP_W'(yz) * UVP_W'(o1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xxo <= UVO_W'((qxx + UVP_W'(HALF)) >>> F);
      yyo <= UVO_W'((qyy + UVP_W'(HALF)) >>> F);
      zzo <= UVO_W'((qzz + UVP_W'(HALF)) >>> F);
      xyo <= UVO_W'((qxy + UVP_W'(HALF)) >>> F);
      xzo <= UVO_W'((qxz + UVP_W'(HALF)) >>> F);
      yzo <= UVO_W'((qyz + UVP_W'(HALF)) >>> F);
      xs2 <= xs;
      ys2 <= ys;
      zs2 <= zs;
      c2  <= c1;
    end
  end

  // stage p3: element sums and saturation into the output register
  logic signed [SUM_W-1:0] e [0:8];
  aarm_pkg::elem_t         sat [0:8];
  logic [8:0]              clip;

  always_comb begin
    e[0] = SUM_W'(c2)  + SUM_W'(xxo);
    e[1] = SUM_W'(xyo) - SUM_W'(zs2);
    e[2] = SUM_W'(xzo) + SUM_W'(ys2);
    e[3] = SUM_W'(xyo) + SUM_W'(zs2);
    e[4] = SUM_W'(c2)  + SUM_W'(yyo);
    e[5] = SUM_W'(yzo) - SUM_W'(xs2);
    e[6] = SUM_W'(xzo) - SUM_W'(ys2);
    e[7] = SUM_W'(yzo) + SUM_W'(xs2);
    e[8] = SUM_W'(c2)  + SUM_W'(zzo);
    for (int k = 0; k < 9; k++) begin
      if (e[k] > SUM_W'(aarm_pkg::OUT_MAX)) begin
        sat[k]  = aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX);
        clip[k] = 1'b1;
      end else if (e[k] < SUM_W'(aarm_pkg::OUT_MIN)) begin
        sat[k]  = aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN);
        clip[k] = 1'b1;
      end else begin
        sat[k]  = aarm_pkg::OUT_W'(e[k]);
        clip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.m_r0c0  <= sat[0];
      rsp.m_r0c1  <= sat[1];
      rsp.m_r0c2  <= sat[2];
      rsp.m_r1c0  <= sat[3];
      rsp.m_r1c1  <= sat[4];
      rsp.m_r1c2  <= sat[5];
      rsp.m_r2c0  <= sat[6];
      rsp.m_r2c1  <= sat[7];
      rsp.m_r2c2  <= sat[8];
      rsp.clipped <= |clip;
    end
  end

  // a clipped result must show at least one element pinned at a rail
  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.clipped |->
      rsp.m_r0c0 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r0c0 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r0c1 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r0c1 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r0c2 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r0c2 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r1c0 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r1c0 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r1c1 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r1c1 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r1c2 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r1c2 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r2c0 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r2c0 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r2c1 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r2c1 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN) ||
      rsp.m_r2c2 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MAX) ||
      rsp.m_r2c2 == aarm_pkg::OUT_W'(aarm_pkg::OUT_MIN))
    else $error("clipped set with no element at a rail");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid && !p1_valid && !p2_valid)
    else $error("valid bit survived reset");

  // a stall freezes the product stages
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(p1_valid) && $stable(p2_valid) && $stable(xyo) && $stable(c2))
    else $error("product stage moved during stall");

  // an accepted request reaches the cordic's first register
  a_enter: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> u_cordic.v0)
    else $error("accepted request lost at entry");

endmodule

>>> hw/rtl/aarm_cordic.sv
`timescale 1ns / 1ps
// angle reduction and pipelined cordic: degrees in, rounded sine and cosine out
// depends on aarm_pkg; carries the axis alongside as sideband
module aarm_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  aarm_pkg::in_word_t angle,
  input  aarm_pkg::axis_t    in_axis,
  output logic               out_valid,
  output aarm_pkg::trig_t    out_cos,
  output aarm_pkg::trig_t    out_sin,
  output aarm_pkg::axis_t    out_axis
);

  localparam int N     = aarm_pkg::STAGES;
  localparam int SH    = 30 - aarm_pkg::FRAC_BITS;
  localparam int HALF  = 1 << (SH - 1);
  localparam int TURN  = aarm_pkg::TURN_UNITS;
  localparam int QTR   = aarm_pkg::QUARTER_UNITS;

  // stage 0: reduce into one turn
  logic signed [16:0] a1, a2;
  logic [14:0]        a;
  aarm_pkg::axis_t    axis0;
  logic               v0;

  always_comb begin
    a1 = (angle < 0) ? (17'(angle) + 17'(TURN)) : 17'(angle);
    if (a1 < 0) begin
      a2 = a1 + 17'(TURN);
    end else if (a1 >= 17'(TURN)) begin
      a2 = a1 - 17'(TURN);
    end else begin
      a2 = a1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a     <= a2[14:0];
      axis0 <= in_axis;
    end
  end

  // stage 1: quadrant and remainder
  aarm_pkg::quad_t quad_next, quad1;
  logic [12:0]     r_next, r1;
  aarm_pkg::axis_t axis1;
  logic            v1;

  always_comb begin
    if (a >= 15'(3 * QTR)) begin
      quad_next = aarm_pkg::QUAD_3;
      r_next    = 13'(a - 15'(3 * QTR));
    end else if (a >= 15'(2 * QTR)) begin
      quad_next = aarm_pkg::QUAD_2;
      r_next    = 13'(a - 15'(2 * QTR));
    end else if (a >= 15'(QTR)) begin
      quad_next = aarm_pkg::QUAD_1;
      r_next    = 13'(a - 15'(QTR));
    end else begin
      quad_next = aarm_pkg::QUAD_0;
      r_next    = 13'(a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad1 <= quad_next;
      r1    <= r_next;
      axis1 <= axis0;
    end
  end

  // stage 2: radians in q1.30, then the rotation chain
  aarm_pkg::cword_t x [0:N];
  aarm_pkg::cword_t y [0:N];
  aarm_pkg::cword_t z [0:N];
  aarm_pkg::quad_t  qd [0:N];
  aarm_pkg::axis_t  ax [0:N];
  logic             v  [0:N];
  logic [31:0]      zprod;

  assign zprod = 32'(r1) * 32'(aarm_pkg::RAD_PER_UNIT_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= aarm_pkg::CW'(aarm_pkg::CORDIC_GAIN_Q30);
      y[0]  <= '0;
      z[0]  <= aarm_pkg::CW'(zprod);
      qd[0] <= quad1;
      ax[0] <= axis1;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    aarm_pkg::cword_t dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - aarm_pkg::atan_q30(i);
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + aarm_pkg::atan_q30(i);
        end
        qd[i+1] <= qd[i];
        ax[i+1] <= ax[i];
      end
    end
  end

  // final stage: fold into the quadrant and round to the output format
  aarm_pkg::cword_t c30, s30, cr, sr;

  always_comb begin
    case (qd[N])
      aarm_pkg::QUAD_0: begin c30 = x[N];  s30 = y[N];  end
      aarm_pkg::QUAD_1: begin c30 = -y[N]; s30 = x[N];  end
      aarm_pkg::QUAD_2: begin c30 = -x[N]; s30 = -y[N]; end
      default:          begin c30 = y[N];  s30 = -x[N]; end
    endcase
    cr = (c30 + aarm_pkg::CW'(HALF)) >>> SH;
    sr = (s30 + aarm_pkg::CW'(HALF)) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cos  <= aarm_pkg::C_W'(cr);
      out_sin  <= aarm_pkg::C_W'(sr);
      out_axis <= ax[N];
    end
  end

endmodule
